// ===== hw/rtl/h2r_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
package h2r_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned HUE_W    = 11;
    localparam int unsigned SEXT_W   = 3;
    localparam int unsigned OPND_W   = 9;
    localparam int unsigned PROD_W   = 16;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_IDX_W  = $clog2(Q_DEPTH);

    localparam logic [SEXT_W-1:0] SEXT_LAST = 3'd5;

    localparam logic [SEXT_W-1:0] SEXT_0 = 3'd0;
    localparam logic [SEXT_W-1:0] SEXT_1 = 3'd1;
    localparam logic [SEXT_W-1:0] SEXT_2 = 3'd2;
    localparam logic [SEXT_W-1:0] SEXT_3 = 3'd3;
    localparam logic [SEXT_W-1:0] SEXT_4 = 3'd4;

    // Classified pixel handed from front to back.
    typedef struct packed {
        logic                grey;
        logic [SEXT_W-1:0]   sextant;
        logic [OPND_W-1:0]   slope_opnd;
        logic [LEVEL_W-1:0]  sat;
        logic [LEVEL_W-1:0]  val;
    } t_item;

    // Product plus its own high byte, high byte returned.
    function automatic logic [LEVEL_W-1:0] corrected_high(input logic [PROD_W-1:0] w);
        logic [PROD_W-1:0] s;
        s = w + {8'd0, w[PROD_W-1:LEVEL_W]};
        return s[PROD_W-1:LEVEL_W];
    endfunction

endpackage

// ===== hw/rtl/h2r_front.sv =====
// Front end: takes pixels, clamps the sextant and prepares the slope operand.
module h2r_front
    import h2r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [HUE_W-1:0]   i_hue,
    input  logic [LEVEL_W-1:0] i_saturation,
    input  logic [LEVEL_W-1:0] i_brightness,
    output logic               o_vld,
    output t_item              o_item,
    input  logic               i_q_full
);

    logic              r_vld;
    logic              n_vld;
    t_item             r_item;
    t_item             n_item;
    logic              accept;
    logic              adv;
    logic [SEXT_W-1:0] sext;
    logic [LEVEL_W-1:0] frac;

    assign adv    = r_vld && !i_q_full;
    assign o_full = r_vld && i_q_full;
    assign accept = i_push && !o_full;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_comb begin
        sext = i_hue[HUE_W-1:LEVEL_W];
        if (sext > SEXT_LAST) begin
            sext = SEXT_LAST;
        end
        frac = i_hue[LEVEL_W-1:0];
        n_item.grey    = (i_saturation == '0);
        n_item.sextant = sext;
        n_item.sat     = i_saturation;
        n_item.val     = i_brightness;
        // rising sextants use 256 - frac, which is 256 itself at zero fraction
        if (!sext[0]) begin
            n_item.slope_opnd = 9'd256 - {1'b0, frac};
        end else begin
            n_item.slope_opnd = {1'b0, frac};
        end
        n_vld = accept || (r_vld && !adv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hw/rtl/h2r_queue.sv =====
// Short first-in first-out queue between front and back.
module h2r_queue
    import h2r_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_vld,
    output t_item o_item
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_IDX_W:0]   r_wr_ptr;
    logic [Q_IDX_W:0]   r_rd_ptr;
    logic [Q_IDX_W:0]   n_wr_ptr;
    logic [Q_IDX_W:0]   n_rd_ptr;
    logic               do_wr;
    logic               do_rd;

    assign o_vld  = (r_wr_ptr != r_rd_ptr);
    assign o_full = (r_wr_ptr[Q_IDX_W] != r_rd_ptr[Q_IDX_W])
                 && (r_wr_ptr[Q_IDX_W-1:0] == r_rd_ptr[Q_IDX_W-1:0]);
    assign do_wr  = i_wr && !o_full;
    assign do_rd  = i_rd && o_vld;
    assign o_item = r_mem[r_rd_ptr[Q_IDX_W-1:0]];

    always_comb begin
        n_wr_ptr = r_wr_ptr + (Q_IDX_W+1)'(do_wr);
        n_rd_ptr = r_rd_ptr + (Q_IDX_W+1)'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr[Q_IDX_W-1:0]] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/h2r_back.sv =====
// Back end: three-stage multiply pipeline and channel routing.
module h2r_back
    import h2r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  t_item              i_item,
    output logic               o_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [LEVEL_W-1:0] o_red,
    output logic [LEVEL_W-1:0] o_green,
    output logic [LEVEL_W-1:0] o_blue
);

    logic en;

    // stage 1: both first products
    logic              r_s1_vld;
    t_item             r_s1_item;
    logic [PROD_W-1:0] r_s1_wbot;
    logic [PROD_W-1:0] r_s1_wsl;
    logic [PROD_W-1:0] n_s1_wbot;
    logic [PROD_W-1:0] n_s1_wsl;
    logic [OPND_W+LEVEL_W-1:0] sl_full;

    // stage 2: bottom level and slope product
    logic               r_s2_vld;
    logic               r_s2_grey;
    logic [SEXT_W-1:0]  r_s2_sext;
    logic [LEVEL_W-1:0] r_s2_val;
    logic [LEVEL_W-1:0] r_s2_bot;
    logic [PROD_W-1:0]  r_s2_p;
    logic [LEVEL_W-1:0] n_s2_bot;
    logic [LEVEL_W-1:0] sub;
    logic [PROD_W-1:0]  n_s2_p;

    // stage 3: output register
    logic               r_out_vld;
    logic [LEVEL_W-1:0] r_red;
    logic [LEVEL_W-1:0] r_green;
    logic [LEVEL_W-1:0] r_blue;
    logic [LEVEL_W-1:0] n_red;
    logic [LEVEL_W-1:0] n_green;
    logic [LEVEL_W-1:0] n_blue;
    logic [LEVEL_W-1:0] top;
    logic [LEVEL_W-1:0] slope;

    assign en      = !r_out_vld || i_pop;
    assign o_rd    = en;
    assign o_empty = !r_out_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    always_comb begin
        n_s1_wbot = {8'd0, i_item.val} * {8'd0, ~i_item.sat} + 16'd1;
        sl_full   = i_item.sat * i_item.slope_opnd;
        n_s1_wsl  = sl_full[PROD_W-1:0];
    end

    always_comb begin
        n_s2_bot = corrected_high(r_s1_wbot);
        sub      = corrected_high(r_s1_wsl);
        n_s2_p   = {8'd0, r_s1_item.val} * {8'd0, ~sub}
                 + {9'd0, r_s1_item.val[LEVEL_W-1:1]};
    end

    always_comb begin
        top   = r_s2_val;
        slope = r_s2_p[PROD_W-1:LEVEL_W];
        if (r_s2_grey) begin
            n_red   = r_s2_val;
            n_green = r_s2_val;
            n_blue  = r_s2_val;
        end else begin
            unique case (r_s2_sext)
                SEXT_0: begin
                    n_red = top;      n_green = slope;    n_blue = r_s2_bot;
                end
                SEXT_1: begin
                    n_red = slope;    n_green = top;      n_blue = r_s2_bot;
                end
                SEXT_2: begin
                    n_red = r_s2_bot; n_green = top;      n_blue = slope;
                end
                SEXT_3: begin
                    n_red = r_s2_bot; n_green = slope;    n_blue = top;
                end
                SEXT_4: begin
                    n_red = slope;    n_green = r_s2_bot; n_blue = top;
                end
                default: begin
                    n_red = top;      n_green = r_s2_bot; n_blue = slope;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= i_vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_item <= i_item;
            r_s1_wbot <= n_s1_wbot;
            r_s1_wsl  <= n_s1_wsl;
            r_s2_grey <= r_s1_item.grey;
            r_s2_sext <= r_s1_item.sextant;
            r_s2_val  <= r_s1_item.val;
            r_s2_bot  <= n_s2_bot;
            r_s2_p    <= n_s2_p;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
        end
    end

endmodule

// ===== hw/rtl/hsv_to_rgb_8bit_top.sv =====
// HSV to RGB converter, top level: front end, queue and back end.
//
// Usage notes
// - Input side is a queue: a transaction happens on a rising edge with
//   push high and full low. i_hue carries the sextant in bits 10..8
//   (six and seven act as five) and the fraction in bits 7..0.
// - Output side is a queue as well: while empty is low the oldest pixel
//   sits on o_red/o_green/o_blue; a transaction happens on a rising edge
//   with pop high and empty low.
// - Zero saturation gives grey: every channel equals i_brightness.
// - Throughput: one pixel per clock, sustained, with pop held high.
// - A pixel taken passes through the front register, the queue, two
//   multiply stages and the output register before it is shown.
// - The four-deep queue between front and back lets the front keep
//   taking pixels while the receiver stalls; once the queue and front
//   register are full, full rises.
// - Reset (i_rst_n low at an edge, synchronous) drops every pixel in
//   flight: empty goes high and full goes low.
module hsv_to_rgb_8bit_top
    import h2r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [HUE_W-1:0]   i_hue,
    input  logic [LEVEL_W-1:0] i_saturation,
    input  logic [LEVEL_W-1:0] i_brightness,
    output logic               empty,
    input  logic               pop,
    output logic [LEVEL_W-1:0] o_red,
    output logic [LEVEL_W-1:0] o_green,
    output logic [LEVEL_W-1:0] o_blue
);

    logic  f_vld;
    t_item f_item;
    logic  q_full;
    logic  q_vld;
    t_item q_item;
    logic  b_rd;

    // classify and clamp
    h2r_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_vld        (f_vld),
        .o_item       (f_item),
        .i_q_full     (q_full)
    );

    // decoupling queue
    h2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_vld),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_rd    (b_rd),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    // arithmetic and routing; stalls as one when the output is held
    h2r_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_item  (q_item),
        .o_rd    (b_rd),
        .o_empty (empty),
        .i_pop   (pop),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

// ===== tb/hsv_to_rgb_8bit_chk.sv =====
// Checker for the HSV to RGB converter: predicts each pixel and compares the results.
module hsv_to_rgb_8bit_chk
    import h2r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [HUE_W-1:0]   i_hue,
    input  logic [LEVEL_W-1:0] i_saturation,
    input  logic [LEVEL_W-1:0] i_brightness,
    input  logic               empty,
    input  logic               pop,
    input  logic [LEVEL_W-1:0] i_red,
    input  logic [LEVEL_W-1:0] i_green,
    input  logic [LEVEL_W-1:0] i_blue,
    output int                 o_fail_cnt,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_rgb;

    t_rgb rgb_due[$];
    int   fail_cnt = 0;
    int   checked  = 0;

    // High byte of a 16-bit product after adding that same high byte back in.
    function automatic logic [LEVEL_W-1:0] high_byte_fixed(input logic [15:0] w);
        logic [15:0] t;
        t = w + {8'h00, w[15:8]};
        return t[15:8];
    endfunction

    function automatic t_rgb hsv_pixel(input logic [HUE_W-1:0]   hue,
                                       input logic [LEVEL_W-1:0] sat,
                                       input logic [LEVEL_W-1:0] val);
        logic [SEXT_W-1:0]  sext;
        logic [15:0]        v16, s16, f16, prod;
        logic [LEVEL_W-1:0] top, bottom, slope, sub;
        t_rgb               px;
        v16 = {8'h00, val};
        s16 = {8'h00, sat};
        f16 = {8'h00, hue[7:0]};
        if (sat == '0) begin
            px = '{red: val, green: val, blue: val};
            return px;
        end
        sext = hue[10:8];
        if (sext > SEXT_LAST)
            sext = SEXT_LAST;
        top    = val;
        prod   = v16 * (16'h00ff - s16) + 16'd1;
        bottom = high_byte_fixed(prod);
        if (!sext[0])
            prod = (f16 == '0) ? {sat, 8'h00} : s16 * (16'd256 - f16);
        else
            prod = s16 * f16;
        sub   = high_byte_fixed(prod);
        prod  = v16 * (16'h00ff - {8'h00, sub}) + {9'h000, val[7:1]};
        slope = prod[15:8];
        case (sext)
            SEXT_0:  px = '{red: top,    green: slope,  blue: bottom};
            SEXT_1:  px = '{red: slope,  green: top,    blue: bottom};
            SEXT_2:  px = '{red: bottom, green: top,    blue: slope};
            SEXT_3:  px = '{red: bottom, green: slope,  blue: top};
            SEXT_4:  px = '{red: slope,  green: bottom, blue: top};
            default: px = '{red: top,    green: bottom, blue: slope};
        endcase
        return px;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rgb want;
        if (i_rst_n) begin
            if (push && !full)
                rgb_due.push_back(hsv_pixel(i_hue, i_saturation, i_brightness));
            if (pop && !empty) begin
                checked++;
                if (rgb_due.size() == 0) begin
                    $error("unexpected pixel r=%0d g=%0d b=%0d", i_red, i_green, i_blue);
                    fail_cnt++;
                end else begin
                    want = rgb_due.pop_front();
                    if (i_red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, i_red);
                        fail_cnt++;
                    end
                    if (i_green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, i_green);
                        fail_cnt++;
                    end
                    if (i_blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, i_blue);
                        fail_cnt++;
                    end
                end
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= rgb_due.size();
        o_checked  <= checked;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the HSV to RGB converter: clock, reset, stimulus and verdict.
module tb;
    import h2r_pkg::*;

    localparam int N_RANDOM   = 1500;
    localparam int IDLE_LIMIT = 2000;   // cycles without any transaction
    localparam int SETTLE     = 12;     // margin for the pipeline to show any stray pixel

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [HUE_W-1:0]   i_hue;
    logic [LEVEL_W-1:0] i_saturation;
    logic [LEVEL_W-1:0] i_brightness;
    logic               empty;
    logic               pop;
    logic [LEVEL_W-1:0] o_red;
    logic [LEVEL_W-1:0] o_green;
    logic [LEVEL_W-1:0] o_blue;

    int fail_cnt, pending, checked;
    int n_sent    = 0;
    int n_grey    = 0;
    int n_clamped = 0;

    hsv_to_rgb_8bit_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .empty        (empty),
        .pop          (pop),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    hsv_to_rgb_8bit_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .empty        (empty),
        .pop          (pop),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake on either side ends the run as a failure.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Sender. Entered and left at a falling edge; push stays high on the way
    // out so that back-to-back pixels need no second assignment in a step.
    bit send_calm = 1'b0;

    task automatic send_pixel(input logic [HUE_W-1:0]   hue,
                              input logic [LEVEL_W-1:0] sat,
                              input logic [LEVEL_W-1:0] val);
        int gap;
        if ($urandom_range(0, 49) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push         = 1'b1;
        i_hue        = hue;
        i_saturation = sat;
        i_brightness = val;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        n_sent++;
        if (sat == '0)
            n_grey++;
        else if (hue[10:8] > SEXT_LAST)
            n_clamped++;
        @(negedge i_clk);
    endtask

    // Receiver: random stalls between pixels, with calm stretches.
    task automatic drain_pixels();
        int  gap;
        bit  calm;
        calm = 1'b0;
        forever begin
            if ($urandom_range(0, 49) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            forever begin
                @(posedge i_clk);
                if (!empty)
                    break;
            end
            @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] sat, val;
        int                 pick;

        push         = 1'b0;
        pop          = 1'b0;
        i_hue        = '0;
        i_saturation = '0;
        i_brightness = '0;
        i_rst_n      = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            drain_pixels();
        join_none

        // Directed: grey at the hue extremes, every sextant at both ends of
        // its fraction (clamped sextants included), zero fraction in rising
        // sextants, and the level extremes.
        send_pixel(11'h000, 8'd0, 8'd0);
        send_pixel(11'h7ff, 8'd0, 8'd255);
        send_pixel(11'h3a5, 8'd0, 8'd77);
        for (int sx = 0; sx < 8; sx++) begin
            send_pixel({3'(sx), 8'h00}, 8'd255, 8'd255);
            send_pixel({3'(sx), 8'hff}, 8'd200, 8'd255);
        end
        send_pixel(11'h280, 8'd1,   8'd1);
        send_pixel(11'h100, 8'd128, 8'd0);
        send_pixel(11'h0ff, 8'd255, 8'd128);
        send_pixel(11'h500, 8'd255, 8'd1);
        send_pixel(11'h401, 8'd1,   8'd255);

        // Random: full hue range with a bias toward zero fraction, and the
        // level extremes drawn more often than a flat spread would give.
        repeat (N_RANDOM) begin
            hue = 11'($urandom_range(0, 2047));
            if ($urandom_range(0, 9) == 0)
                hue[7:0] = '0;
            pick = $urandom_range(0, 9);
            sat  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            val  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            send_pixel(hue, sat, val);
        end
        push = 1'b0;

        // Drain, then give the pipeline time to show any stray pixel.
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d pixels: %0d grey, %0d in clamped sextants", n_sent, n_grey,
                 n_clamped);
        $display("compared %0d pixels under random stalls on both sides", checked);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
